/* rtl/core/esf_pkg.sv */
// esf_pkg: shared types and constants of the encoder speed filter
// no dependencies; used by the top level and the serial arithmetic units
package esf_pkg;

    localparam int COUNT_W = 16;
    localparam int SPEED_W = 32;
    localparam int TOTAL_W = 32;
    localparam int PPS_W   = 26;
    localparam int IV_W    = 8;
    localparam int ALPHA_W = 17;
    localparam int PPM_W   = 20;
    localparam int PPR_W   = 16;
    localparam int CFG_W   = 20;
    localparam int FRAC_W  = 16;

    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [SPEED_W-1:0] speed_t;
    typedef logic [TOTAL_W-1:0] total_t;

    // operation codes
    localparam logic [1:0] OP_SAMPLE  = 2'd0;
    localparam logic [1:0] OP_CLEAR   = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    // register indexes
    localparam logic [1:0] CFG_INTERVAL = 2'd0;
    localparam logic [1:0] CFG_ALPHA    = 2'd1;
    localparam logic [1:0] CFG_PPM      = 2'd2;
    localparam logic [1:0] CFG_PPR      = 2'd3;

    localparam logic [IV_W-1:0]    INTERVAL_RST = 8'd10;
    localparam logic [ALPHA_W-1:0] ALPHA_RST    = 17'd32768;
    localparam logic [PPM_W-1:0]   PPM_RST      = 20'd1000;
    localparam logic [PPR_W-1:0]   PPR_RST      = 16'd1000;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'h10000;
    localparam count_t             COUNT_MAX = 16'hFFFF;
    localparam logic [9:0]         MILLI     = 10'd1000;

    // unit handshake between sequencer and a serial unit
    typedef struct packed {
        logic start;
    } unit_ctl_t;

    typedef struct packed {
        logic busy;
    } unit_sts_t;

endpackage

/* rtl/core/esf_div.sv */
// esf_div: restoring divider, one quotient bit per cycle
// depends on esf_pkg for the unit control and status structs
module esf_div #(
    parameter int N = 32,
    parameter int D = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  esf_pkg::unit_ctl_t   ctl,
    input  logic [N-1:0]         dividend,
    input  logic [D-1:0]         divisor,
    output esf_pkg::unit_sts_t   sts,
    output logic [N-1:0]         quotient
);

    localparam int CW = (N > 1) ? $clog2(N) : 1;
    localparam logic [CW-1:0] LAST = CW'(N - 1);

    logic          busy_reg, busy_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [N-1:0]  quo_reg, quo_next;
    logic [D-1:0]  rem_reg, rem_next;
    logic [D-1:0]  dvs_reg, dvs_next;
    logic [D:0]    trial;
    logic [D:0]    diff;
    logic          ge;

    assign trial = {rem_reg, quo_reg[N-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign ge    = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (ctl.start)
        begin
            busy_next = 1'b1;
            cnt_next  = LAST;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[N-2:0], ge};
            rem_next = ge ? diff[D-1:0] : trial[D-1:0];
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign sts.busy = busy_reg;
    assign quotient = quo_reg;

endmodule

/* rtl/core/esf_mul.sv */
// esf_mul: shift-add multiplier, one multiplier bit per cycle
// depends on esf_pkg for the unit control and status structs
module esf_mul #(
    parameter int M = 17,
    parameter int W = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  esf_pkg::unit_ctl_t   ctl,
    input  logic [M-1:0]         mplier,
    input  logic [W-1:0]         mcand,
    output esf_pkg::unit_sts_t   sts,
    output logic [M+W-1:0]       product
);

    localparam int CW = (M > 1) ? $clog2(M) : 1;
    localparam logic [CW-1:0] LAST = CW'(M - 1);

    logic           busy_reg, busy_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [M+W-1:0] prod_reg, prod_next;
    logic [W-1:0]   mc_reg, mc_next;
    logic [W:0]     sum;

    assign sum = {1'b0, prod_reg[M+W-1:M]} + (prod_reg[0] ? {1'b0, mc_reg} : '0);

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        prod_next = prod_reg;
        mc_next   = mc_reg;
        if (ctl.start)
        begin
            busy_next = 1'b1;
            cnt_next  = LAST;
            prod_next = {{W{1'b0}}, mplier};
            mc_next   = mcand;
        end
        else if (busy_reg)
        begin
            prod_next = {sum, prod_reg[M-1:1]};
            cnt_next  = cnt_reg - CW'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        mc_reg   <= mc_next;
    end

    assign sts.busy = busy_reg;
    assign product  = prod_reg;

endmodule

/* rtl/core/encoder_speed_filter.sv */
// encoder_speed_filter: encoder count fold, low-pass speed, total and derived rates
// depends on esf_pkg, esf_mul and esf_div
//
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------------------
//  in       | in_valid / in_ready   | operation, raw_count, counting_down
//  out      | out_valid / out_ready | count_magnitude, direction, filtered_speed,
//           |                       | total_count, pulse_rate, speed_mps, rotations
//  cfg      | cfg_write             | cfg_index, cfg_data
//
// an item goes from accept through S_START_A, a wait on the 17-bit serial multipliers, S_START_B,
// a wait on the 48-bit filter divider and back to S_IDLE; the sequencer leaves S_WAIT_B and loads
// the result only once the output register is free
// one item at a time; in_ready is high only while no item is at work
// a finished item waits in the output register, so the next item is taken meanwhile
// reset sets the registers to their defaults and clears count, speed and total
module encoder_speed_filter (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          operation,
    input  logic [esf_pkg::COUNT_W-1:0]         raw_count,
    input  logic                                counting_down,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [esf_pkg::COUNT_W-1:0]         count_magnitude,
    output logic                                direction,
    output logic [esf_pkg::SPEED_W-1:0]         filtered_speed,
    output logic [esf_pkg::TOTAL_W-1:0]         total_count,
    output logic [esf_pkg::PPS_W-1:0]           pulse_rate,
    output logic [31:0]                         speed_mps,
    output logic [31:0]                         rotations,
    input  logic                                cfg_write,
    input  logic [1:0]                          cfg_index,
    input  logic [esf_pkg::CFG_W-1:0]           cfg_data
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_START_A = 3'd1;
    localparam logic [2:0] S_WAIT_A  = 3'd2;
    localparam logic [2:0] S_START_B = 3'd3;
    localparam logic [2:0] S_WAIT_B  = 3'd4;

    localparam int AC_W    = esf_pkg::ALPHA_W + esf_pkg::COUNT_W;
    localparam int KEEP_W  = esf_pkg::ALPHA_W + esf_pkg::SPEED_W;
    localparam int FRESH_W = 32 + esf_pkg::FRAC_W;
    localparam int MPS_W   = esf_pkg::PPS_W + esf_pkg::FRAC_W;

    logic [2:0] state_reg, state_next;

    // configuration
    logic [esf_pkg::IV_W-1:0]    interval_reg;
    logic [esf_pkg::ALPHA_W-1:0] alpha_reg;
    logic [esf_pkg::PPM_W-1:0]   ppm_reg;
    logic [esf_pkg::PPR_W-1:0]   ppr_reg;

    // architectural state
    esf_pkg::count_t count_reg, count_next;
    logic            dir_reg, dir_next;
    esf_pkg::speed_t speed_reg, speed_next;
    esf_pkg::total_t total_reg, total_next;
    logic            sample_reg, sample_next;

    // output register
    logic                        out_valid_reg, out_valid_next;
    esf_pkg::count_t             o_count_reg;
    logic                        o_dir_reg;
    esf_pkg::speed_t             o_speed_reg;
    esf_pkg::total_t             o_total_reg;
    logic [esf_pkg::PPS_W-1:0]   o_pps_reg;
    logic [31:0]                 o_mps_reg;
    logic [31:0]                 o_rot_reg;

    logic                        in_acc;
    logic                        load;
    logic                        phase_a_done;
    logic                        phase_b_done;
    logic [esf_pkg::IV_W-1:0]    iv_nz;
    logic [esf_pkg::PPM_W-1:0]   ppm_nz;
    logic [esf_pkg::PPR_W-1:0]   ppr_nz;
    logic [esf_pkg::ALPHA_W-1:0] alpha_sat;
    esf_pkg::count_t             fold_count;

    esf_pkg::unit_ctl_t ctl_a, ctl_b;
    esf_pkg::unit_sts_t keep_sts, ac_sts, q_sts, fresh_sts, pps_sts, mps_sts, rot_sts;

    logic [KEEP_W-1:0]           keep_prod;
    logic [AC_W-1:0]             ac_prod;
    esf_pkg::count_t             q_quo;
    logic [FRESH_W-1:0]          fresh_quo;
    logic [esf_pkg::PPS_W-1:0]   pps_quo;
    logic [MPS_W-1:0]            mps_quo;
    logic [31:0]                 rot_quo;
    logic [esf_pkg::PPS_W-1:0]   pps_dividend;
    logic [esf_pkg::PPS_W-1:0]   q_milli;
    logic [KEEP_W:0]             filt_sum;
    esf_pkg::speed_t             new_speed;
    logic [31:0]                 mps_sat;

    assign iv_nz     = (interval_reg == '0) ? esf_pkg::IV_W'(1) : interval_reg;
    assign ppm_nz    = (ppm_reg == '0) ? esf_pkg::PPM_W'(1) : ppm_reg;
    assign ppr_nz    = (ppr_reg == '0) ? esf_pkg::PPR_W'(1) : ppr_reg;
    assign alpha_sat = (alpha_reg > esf_pkg::ALPHA_ONE) ? esf_pkg::ALPHA_ONE : alpha_reg;
    assign fold_count = counting_down ? (esf_pkg::COUNT_MAX - raw_count) : raw_count;

    assign in_ready = (state_reg == S_IDLE);
    assign in_acc   = in_valid && in_ready;

    assign ctl_a.start = (state_reg == S_START_A);
    assign ctl_b.start = (state_reg == S_START_B);

    assign phase_a_done = !(keep_sts.busy || ac_sts.busy || q_sts.busy);
    assign phase_b_done = !(fresh_sts.busy || pps_sts.busy || mps_sts.busy || rot_sts.busy);
    assign load = (state_reg == S_WAIT_B) && phase_b_done && (!out_valid_reg || out_ready);

    assign pps_dividend = esf_pkg::PPS_W'(count_reg) * esf_pkg::PPS_W'(esf_pkg::MILLI);
    assign q_milli      = esf_pkg::PPS_W'(q_quo) * esf_pkg::PPS_W'(esf_pkg::MILLI);

    // new speed = (keep + fresh) >> 16
    assign filt_sum  = {1'b0, keep_prod} + (KEEP_W + 1)'(fresh_quo);
    assign new_speed = filt_sum[esf_pkg::FRAC_W +: esf_pkg::SPEED_W];
    assign mps_sat   = (|mps_quo[MPS_W-1:32]) ? 32'hFFFF_FFFF : mps_quo[31:0];

    esf_mul #(.M(esf_pkg::ALPHA_W), .W(esf_pkg::SPEED_W)) u_mul_keep (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl_a),
        .mplier  (esf_pkg::ALPHA_ONE - alpha_sat),
        .mcand   (speed_reg),
        .sts     (keep_sts),
        .product (keep_prod)
    );

    esf_mul #(.M(esf_pkg::ALPHA_W), .W(esf_pkg::COUNT_W)) u_mul_ac (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl_a),
        .mplier  (alpha_sat),
        .mcand   (count_reg),
        .sts     (ac_sts),
        .product (ac_prod)
    );

    esf_div #(.N(esf_pkg::COUNT_W), .D(esf_pkg::IV_W)) u_div_q (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl_a),
        .dividend (count_reg),
        .divisor  (iv_nz),
        .sts      (q_sts),
        .quotient (q_quo)
    );

    esf_div #(.N(FRESH_W), .D(esf_pkg::IV_W)) u_div_fresh (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl_b),
        .dividend ({ac_prod[31:0], {esf_pkg::FRAC_W{1'b0}}}),
        .divisor  (iv_nz),
        .sts      (fresh_sts),
        .quotient (fresh_quo)
    );

    esf_div #(.N(esf_pkg::PPS_W), .D(esf_pkg::IV_W)) u_div_pps (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl_b),
        .dividend (pps_dividend),
        .divisor  (iv_nz),
        .sts      (pps_sts),
        .quotient (pps_quo)
    );

    esf_div #(.N(MPS_W), .D(esf_pkg::PPM_W)) u_div_mps (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl_b),
        .dividend ({q_milli, {esf_pkg::FRAC_W{1'b0}}}),
        .divisor  (ppm_nz),
        .sts      (mps_sts),
        .quotient (mps_quo)
    );

    esf_div #(.N(esf_pkg::TOTAL_W), .D(esf_pkg::PPR_W)) u_div_rot (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl_b),
        .dividend (total_reg),
        .divisor  (ppr_nz),
        .sts      (rot_sts),
        .quotient (rot_quo)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = S_START_A;
                end
            end
            S_START_A:
            begin
                state_next = S_WAIT_A;
            end
            S_WAIT_A:
            begin
                if (phase_a_done)
                begin
                    state_next = S_START_B;
                end
            end
            S_START_B:
            begin
                state_next = S_WAIT_B;
            end
            S_WAIT_B:
            begin
                if (load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        count_next  = count_reg;
        dir_next    = dir_reg;
        speed_next  = speed_reg;
        total_next  = total_reg;
        sample_next = sample_reg;
        if (in_acc)
        begin
            sample_next = 1'b0;
            unique case (operation)
                esf_pkg::OP_SAMPLE:
                begin
                    count_next  = fold_count;
                    dir_next    = counting_down;
                    total_next  = total_reg + esf_pkg::TOTAL_W'(fold_count);
                    sample_next = 1'b1;
                end
                esf_pkg::OP_CLEAR:
                begin
                    total_next = '0;
                end
                esf_pkg::OP_RESTART:
                begin
                    count_next = '0;
                    speed_next = '0;
                    total_next = '0;
                end
                default:
                begin
                    sample_next = 1'b0;
                end
            endcase
        end
        else if (load && sample_reg)
        begin
            speed_next = new_speed;
        end
    end

    always_comb
    begin
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            dir_reg       <= 1'b0;
            speed_reg     <= '0;
            total_reg     <= '0;
            sample_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            interval_reg  <= esf_pkg::INTERVAL_RST;
            alpha_reg     <= esf_pkg::ALPHA_RST;
            ppm_reg       <= esf_pkg::PPM_RST;
            ppr_reg       <= esf_pkg::PPR_RST;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            dir_reg       <= dir_next;
            speed_reg     <= speed_next;
            total_reg     <= total_next;
            sample_reg    <= sample_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    esf_pkg::CFG_INTERVAL: interval_reg <= cfg_data[esf_pkg::IV_W-1:0];
                    esf_pkg::CFG_ALPHA:    alpha_reg    <= cfg_data[esf_pkg::ALPHA_W-1:0];
                    esf_pkg::CFG_PPM:      ppm_reg      <= cfg_data[esf_pkg::PPM_W-1:0];
                    esf_pkg::CFG_PPR:      ppr_reg      <= cfg_data[esf_pkg::PPR_W-1:0];
                    default:               interval_reg <= interval_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            o_count_reg <= count_reg;
            o_dir_reg   <= dir_reg;
            o_speed_reg <= sample_reg ? new_speed : speed_reg;
            o_total_reg <= total_reg;
            o_pps_reg   <= pps_quo;
            o_mps_reg   <= mps_sat;
            o_rot_reg   <= rot_quo;
        end
    end

    assign out_valid       = out_valid_reg;
    assign count_magnitude = o_count_reg;
    assign direction       = o_dir_reg;
    assign filtered_speed  = o_speed_reg;
    assign total_count     = o_total_reg;
    assign pulse_rate      = o_pps_reg;
    assign speed_mps       = o_mps_reg;
    assign rotations       = o_rot_reg;

    // arithmetic units stay quiet between items
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !(keep_sts.busy || ac_sts.busy || q_sts.busy ||
            fresh_sts.busy || pps_sts.busy || mps_sts.busy || rot_sts.busy))
        else $error("serial unit busy while idle");

    // restart clears count, speed and total
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && operation == esf_pkg::OP_RESTART) |=>
            (count_reg == '0 && speed_reg == '0 && total_reg == '0))
        else $error("restart did not clear state");

    // direction moves only on a sample
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && operation != esf_pkg::OP_SAMPLE) |=> $stable(dir_reg))
        else $error("direction changed outside a sample");

    // a new result appears only as the sequencer finishes an item
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> (state_reg == S_IDLE && $past(state_reg) == S_WAIT_B))
        else $error("result loaded outside item completion");

    // speed holds while the sequencer waits on phase A or starts phase B
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WAIT_A || state_reg == S_START_B) |=> $stable(speed_reg))
        else $error("speed changed during work");

endmodule

/* verif/encoder_speed_filter_tb.sv */
`timescale 1ns / 1ps
// encoder_speed_filter_tb: self-checking bench for the encoder speed filter
// drives items, register writes, random stalls; checks every result against a model or table
// depends on esf_pkg and encoder_speed_filter
module encoder_speed_filter_tb;

    localparam logic [1:0] OP_NONE = 2'd3;

    typedef struct packed {
        esf_pkg::count_t                count;
        logic                           dir;
        esf_pkg::speed_t                speed;
        esf_pkg::total_t                total;
        logic [esf_pkg::PPS_W-1:0]      pps;
        logic [31:0]                    mps;
        logic [31:0]                    rot;
    } speed_report_t;

    typedef struct packed {
        logic [1:0]         op;
        esf_pkg::count_t    raw;
        logic               down;
        logic               known;
        speed_report_t      want;
    } stim_row_t;

    localparam speed_report_t ZERO_REPORT = '0;
    localparam speed_report_t FIRST_SAMPLE =
        '{16'd100, 1'b0, 32'd327680, 32'd100, 26'd10000, 32'd655360, 32'd0};
    localparam speed_report_t FIRST_CLEARED =
        '{16'd100, 1'b0, 32'd327680, 32'd0, 26'd10000, 32'd655360, 32'd0};
    localparam speed_report_t RESTART_REVERSE =
        '{16'd0, 1'b1, 32'd0, 32'd0, 26'd0, 32'd0, 32'd0};

    localparam int N_DIRECTED = 18;
    localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        '{OP_NONE,             16'hFFFF, 1'b1, 1'b1, ZERO_REPORT},
        '{esf_pkg::OP_SAMPLE,  16'd100,  1'b0, 1'b1, FIRST_SAMPLE},
        '{esf_pkg::OP_CLEAR,   16'h1234, 1'b1, 1'b1, FIRST_CLEARED},
        '{esf_pkg::OP_SAMPLE,  16'h0000, 1'b1, 1'b0, ZERO_REPORT},
        '{esf_pkg::OP_SAMPLE,  16'hFFFF, 1'b1, 1'b0, ZERO_REPORT},
        '{esf_pkg::OP_SAMPLE,  16'hFFFF, 1'b0, 1'b0, ZERO_REPORT},
        '{esf_pkg::OP_SAMPLE,  16'h0000, 1'b0, 1'b0, ZERO_REPORT},
        '{esf_pkg::OP_SAMPLE,  16'hAAAA, 1'b0, 1'b0, ZERO_REPORT},
        '{esf_pkg::OP_SAMPLE,  16'h5555, 1'b1, 1'b0, ZERO_REPORT},
        '{OP_NONE,             16'h0000, 1'b0, 1'b0, ZERO_REPORT},
        '{esf_pkg::OP_RESTART, 16'hFFFF, 1'b1, 1'b1, RESTART_REVERSE},
        '{esf_pkg::OP_SAMPLE,  16'h5555, 1'b0, 1'b0, ZERO_REPORT},
        '{esf_pkg::OP_SAMPLE,  16'hAAAA, 1'b1, 1'b0, ZERO_REPORT},
        '{esf_pkg::OP_CLEAR,   16'h0000, 1'b0, 1'b0, ZERO_REPORT},
        '{esf_pkg::OP_RESTART, 16'h0000, 1'b0, 1'b1, RESTART_REVERSE},
        '{esf_pkg::OP_SAMPLE,  16'd1,    1'b0, 1'b0, ZERO_REPORT},
        '{esf_pkg::OP_SAMPLE,  16'd9,    1'b0, 1'b0, ZERO_REPORT},
        '{esf_pkg::OP_SAMPLE,  16'd10,   1'b1, 1'b0, ZERO_REPORT}
    };

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_ready;
    logic [1:0]                     operation = OP_NONE;
    esf_pkg::count_t                raw_count = '0;
    logic                           counting_down = 1'b0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    esf_pkg::count_t                count_magnitude;
    logic                           direction;
    esf_pkg::speed_t                filtered_speed;
    esf_pkg::total_t                total_count;
    logic [esf_pkg::PPS_W-1:0]      pulse_rate;
    logic [31:0]                    speed_mps;
    logic [31:0]                    rotations;
    logic                           cfg_write = 1'b0;
    logic [1:0]                     cfg_index = esf_pkg::CFG_INTERVAL;
    logic [esf_pkg::CFG_W-1:0]      cfg_data = '0;

    encoder_speed_filter u_top (.*);

    always #10 clk = ~clk;

    // model copy of registers and state
    logic [esf_pkg::IV_W-1:0]       set_interval = esf_pkg::INTERVAL_RST;
    logic [esf_pkg::ALPHA_W-1:0]    set_alpha    = esf_pkg::ALPHA_RST;
    logic [esf_pkg::PPM_W-1:0]      set_ppm      = esf_pkg::PPM_RST;
    logic [esf_pkg::PPR_W-1:0]      set_ppr      = esf_pkg::PPR_RST;
    esf_pkg::count_t                st_count = '0;
    logic                           st_dir   = 1'b0;
    esf_pkg::speed_t                st_speed = '0;
    esf_pkg::total_t                st_total = '0;

    speed_report_t  pending_reports [$];
    int             mismatches = 0;
    int             n_results = 0;
    bit             tx_calm = 1'b0;
    bit             rx_calm = 1'b0;
    int             rx_wait = 0;

    function automatic speed_report_t advance_filter(input logic [1:0] op,
                                                     input esf_pkg::count_t raw,
                                                     input logic down);
        logic [63:0]   iv;
        logic [63:0]   a;
        logic [63:0]   keep;
        logic [63:0]   fresh;
        logic [63:0]   mps;
        speed_report_t r;
        iv = (set_interval == 0) ? 64'd1 : 64'(set_interval);
        a  = (set_alpha > esf_pkg::ALPHA_ONE) ? 64'(esf_pkg::ALPHA_ONE) : 64'(set_alpha);
        case (op)
            esf_pkg::OP_SAMPLE:
            begin
                st_count = down ? esf_pkg::COUNT_MAX - raw : raw;
                st_dir   = down;
                keep     = (64'(esf_pkg::ALPHA_ONE) - a) * 64'(st_speed);
                fresh    = ((a * 64'(st_count)) << esf_pkg::FRAC_W) / iv;
                st_speed = esf_pkg::speed_t'((keep + fresh) >> esf_pkg::FRAC_W);
                st_total = st_total + esf_pkg::total_t'(st_count);
            end
            esf_pkg::OP_CLEAR:
            begin
                st_total = '0;
            end
            esf_pkg::OP_RESTART:
            begin
                st_count = '0;
                st_speed = '0;
                st_total = '0;
            end
            default:
            begin
            end
        endcase
        mps = (((64'(st_count) / iv) * 64'(esf_pkg::MILLI)) << esf_pkg::FRAC_W)
              / ((set_ppm == 0) ? 64'd1 : 64'(set_ppm));
        r.count = st_count;
        r.dir   = st_dir;
        r.speed = st_speed;
        r.total = st_total;
        r.pps   = esf_pkg::PPS_W'((64'(st_count) * 64'(esf_pkg::MILLI)) / iv);
        r.mps   = (mps > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : mps[31:0];
        r.rot   = st_total / ((set_ppr == 0) ? 32'd1 : 32'(set_ppr));
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("mismatch: %s", msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s got %0h expected %0h",
                                      n_results, name, got, want));
    endtask

    task automatic send_item(input logic [1:0] op, input esf_pkg::count_t raw,
                             input logic down, input logic known,
                             input speed_report_t want);
        int            gap;
        speed_report_t predicted;
        gap = tx_calm ? 0 : $urandom_range(0, 5);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        operation     <= op;
        raw_count     <= raw;
        counting_down <= down;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predicted = advance_filter(op, raw, down);
        pending_reports.push_back(known ? want : predicted);
    endtask

    task automatic hold_until_drained();
        in_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge clk);
        @(posedge clk);
    endtask

    task automatic load_settings(input logic [esf_pkg::IV_W-1:0] iv,
                                 input logic [esf_pkg::ALPHA_W-1:0] alpha,
                                 input logic [esf_pkg::PPM_W-1:0] ppm,
                                 input logic [esf_pkg::PPR_W-1:0] ppr);
        cfg_write <= 1'b1;
        cfg_index <= esf_pkg::CFG_INTERVAL;
        cfg_data  <= esf_pkg::CFG_W'(iv);
        @(posedge clk);
        cfg_index <= esf_pkg::CFG_ALPHA;
        cfg_data  <= esf_pkg::CFG_W'(alpha);
        @(posedge clk);
        cfg_index <= esf_pkg::CFG_PPM;
        cfg_data  <= esf_pkg::CFG_W'(ppm);
        @(posedge clk);
        cfg_index <= esf_pkg::CFG_PPR;
        cfg_data  <= esf_pkg::CFG_W'(ppr);
        @(posedge clk);
        cfg_write <= 1'b0;
        set_interval = iv;
        set_alpha    = alpha;
        set_ppm      = ppm;
        set_ppr      = ppr;
    endtask

    always @(posedge clk)
    begin : drain_side
        int w;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                w = rx_calm ? 0 : $urandom_range(0, 5);
                out_ready <= (w == 0);
                rx_wait   <= (w == 0) ? 0 : w - 1;
            end
            else if (out_valid && !out_ready)
            begin
                if (rx_wait == 0)
                    out_ready <= 1'b1;
                else
                    rx_wait <= rx_wait - 1;
            end
            else if (!out_valid && !out_ready && rx_calm)
            begin
                out_ready <= 1'b1;
            end
            if ($urandom_range(0, 49) == 0)
                rx_calm <= !rx_calm;
        end
    end

    always @(posedge clk)
    begin : check_results
        speed_report_t want;
        if (rst_n && out_valid && out_ready)
        begin
            n_results++;
            if (pending_reports.size() == 0)
            begin
                report_mismatch($sformatf("result %0d arrived with none expected", n_results));
            end
            else
            begin
                want = pending_reports.pop_front();
                check_field("count_magnitude", 32'(count_magnitude), 32'(want.count));
                check_field("direction", 32'(direction), 32'(want.dir));
                check_field("filtered_speed", filtered_speed, want.speed);
                check_field("total_count", total_count, want.total);
                check_field("pulse_rate", 32'(pulse_rate), 32'(want.pps));
                check_field("speed_mps", speed_mps, want.mps);
                check_field("rotations", rotations, want.rot);
            end
        end
    end

    initial
    begin : stimulus
        int                 pick;
        logic [1:0]         op;
        esf_pkg::count_t    raw;
        logic               down;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
            send_item(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].raw, DIRECTED_ROWS[i].down,
                      DIRECTED_ROWS[i].known, DIRECTED_ROWS[i].want);

        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph > 0)
            begin
                hold_until_drained();
                case (ph)
                    1: load_settings(8'd1, esf_pkg::ALPHA_ONE, 20'd1, 16'd1);
                    2: load_settings(8'd255, 17'd0, 20'hFFFFF, 16'hFFFF);
                    3: load_settings(8'd0, 17'h1FFFF, 20'd0, 16'd0);
                    default:
                        load_settings(esf_pkg::IV_W'($urandom_range(0, 255)),
                                      ($urandom_range(0, 3) == 0)
                                          ? esf_pkg::ALPHA_W'($urandom_range(65537, 131071))
                                          : esf_pkg::ALPHA_W'($urandom_range(0, 65536)),
                                      ($urandom_range(0, 1) == 0)
                                          ? esf_pkg::PPM_W'($urandom_range(0, 2000))
                                          : esf_pkg::PPM_W'($urandom_range(0, 1048575)),
                                      ($urandom_range(0, 1) == 0)
                                          ? esf_pkg::PPR_W'($urandom_range(0, 300))
                                          : esf_pkg::PPR_W'($urandom_range(0, 65535)));
                endcase
            end
            for (int k = 0; k < 125; k++)
            begin
                pick = $urandom_range(0, 99);
                op = (pick < 82) ? esf_pkg::OP_SAMPLE : (pick < 88) ? esf_pkg::OP_CLEAR :
                     (pick < 94) ? esf_pkg::OP_RESTART : OP_NONE;
                case ($urandom_range(0, 7))
                    0: raw = '0;
                    1: raw = esf_pkg::COUNT_MAX;
                    2: raw = esf_pkg::count_t'($urandom_range(0, 300));
                    default: raw = esf_pkg::count_t'($urandom);
                endcase
                down = 1'($urandom_range(0, 1));
                if ($urandom_range(0, 29) == 0)
                    tx_calm = !tx_calm;
                if ($urandom_range(0, 39) == 0)
                    hold_until_drained();
                send_item(op, raw, down, 1'b0, ZERO_REPORT);
            end
        end

        hold_until_drained();
        repeat (100) @(posedge clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin : watchdog
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
